// ===== sv/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int unsigned DATA_W    = 32;
    localparam int unsigned PRIO_W    = 16;
    localparam int unsigned COUNT_W   = 5;
    localparam int unsigned RES_TDATA_W = 40;
    localparam int unsigned RES_TUSER_W = 3;

    // Operation codes carried on the input tuser.
    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    // Commands from the controller to the slot array.
    typedef struct packed {
        logic enq;
        logic deq;
    } dp_cmd_t;

    // Status from the slot array back to the controller.
    typedef struct packed {
        logic full;
        logic empty;
    } dp_status_t;

endpackage

// ===== sv/spq_datapath.sv =====
// ----------------------------------------------------------------------------
// spq_datapath
// Sorted slot array with per-slot compare and shift, plus the fill count.
// ----------------------------------------------------------------------------
module spq_datapath #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  spq_pkg::dp_cmd_t          cmd,
    input  logic [31:0]               data_in,
    input  logic signed [15:0]        prio_in,
    output spq_pkg::dp_status_t       status,
    output logic [31:0]               head_data,
    output logic [CNT_W-1:0]          cnt,
    output logic [CNT_W-1:0]          cnt_next
);
    import spq_pkg::*;

    logic [DATA_W-1:0]        slot_data_reg [DEPTH];
    logic signed [PRIO_W-1:0] slot_prio_reg [DEPTH];
    logic [DATA_W-1:0]        slot_data_next [DEPTH];
    logic signed [PRIO_W-1:0] slot_prio_next [DEPTH];
    logic [DEPTH-1:0]         stay;
    logic [CNT_W-1:0]         cnt_reg;

    // A slot stays put on insert when it holds an entry that is not
    // greater than the new priority; these form a prefix of the array.
    for (genvar i = 0; i < DEPTH; i++) begin : g_slot
        always_comb
        begin
            stay[i] = (CNT_W'(i) < cnt_reg) && (slot_prio_reg[i] <= prio_in);
        end

        if (i == 0) begin : g_head
            always_comb
            begin
                slot_data_next[i] = slot_data_reg[i];
                slot_prio_next[i] = slot_prio_reg[i];
                if (cmd.enq && !stay[i])
                begin
                    slot_data_next[i] = data_in;
                    slot_prio_next[i] = prio_in;
                end
                else if (cmd.deq && DEPTH > 1)
                begin
                    slot_data_next[i] = slot_data_reg[(i + 1) % DEPTH];
                    slot_prio_next[i] = slot_prio_reg[(i + 1) % DEPTH];
                end
            end
        end else begin : g_body
            always_comb
            begin
                slot_data_next[i] = slot_data_reg[i];
                slot_prio_next[i] = slot_prio_reg[i];
                if (cmd.enq && !stay[i])
                begin
                    if (stay[i - 1])
                    begin
                        slot_data_next[i] = data_in;
                        slot_prio_next[i] = prio_in;
                    end
                    else
                    begin
                        slot_data_next[i] = slot_data_reg[i - 1];
                        slot_prio_next[i] = slot_prio_reg[i - 1];
                    end
                end
                else if (cmd.deq && i < DEPTH - 1)
                begin
                    slot_data_next[i] = slot_data_reg[(i + 1) % DEPTH];
                    slot_prio_next[i] = slot_prio_reg[(i + 1) % DEPTH];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            slot_data_reg[i] <= slot_data_next[i];
            slot_prio_reg[i] <= slot_prio_next[i];
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.enq)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (cmd.deq)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    assign status.full  = (cnt_reg == CNT_W'(DEPTH));
    assign status.empty = (cnt_reg == '0);
    assign head_data    = slot_data_reg[0];
    assign cnt          = cnt_reg;

endmodule

// ===== sv/spq_ctrl.sv =====
// ----------------------------------------------------------------------------
// spq_ctrl
// Handshake controller: issues slot commands and holds the result register.
// ----------------------------------------------------------------------------
module spq_ctrl #(
    parameter int unsigned CNT_W = 5
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic                    s_axis_tuser,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output spq_pkg::dp_cmd_t        cmd,
    input  spq_pkg::dp_status_t     status,
    input  logic [31:0]             head_data,
    input  logic [CNT_W-1:0]        cnt_next,
    output logic [31:0]             data_out,
    output logic                    data_valid,
    output logic                    was_empty,
    output logic                    rejected_full,
    output logic [4:0]              entry_count
);
    import spq_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_HOLD
    } state_t;

    state_t                   state_reg;
    state_t                   state_next;
    logic                     accept;
    logic                     is_deq;
    logic [CNT_W+COUNT_W-1:0] cnt_ext;

    assign s_axis_tready = (state_reg == ST_IDLE) || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign is_deq        = (s_axis_tuser == CMD_DEQ);
    assign cmd.enq       = accept && !is_deq && !status.full;
    assign cmd.deq       = accept && is_deq && !status.empty;
    assign cnt_ext       = {{COUNT_W{1'b0}}, cnt_next};
    assign m_axis_tvalid = (state_reg == ST_HOLD);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (m_axis_tready && !accept)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            data_out      <= '0;
            data_valid    <= 1'b0;
            was_empty     <= 1'b0;
            rejected_full <= 1'b0;
            entry_count   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                data_out      <= cmd.deq ? head_data : '0;
                data_valid    <= cmd.deq;
                was_empty     <= is_deq && status.empty;
                rejected_full <= !is_deq && status.full;
                entry_count   <= cnt_ext[COUNT_W-1:0];
            end
        end
    end

endmodule

// ===== sv/sorted_priority_queue_top.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue_top
// Bounded priority queue kept sorted by signed priority, FIFO among equals.
// ----------------------------------------------------------------------------
// Usage:
// Each request on the s_axis channel is an enqueue (tuser = 0) of the word
// and priority in tdata, or a dequeue (tuser = 1). Every request yields one
// response on the m_axis channel: the dequeued word, flags for a valid
// dequeue, an empty queue or a refused enqueue, and the entry count after
// the request.
// The slot array compares all slots against the new priority in parallel
// and shifts at once; the response is registered and shows on m_axis in
// the cycle after acceptance, and a new request is taken every cycle
// while the response side keeps up.
// When the receiver stalls, the held response stays and s_axis_tready
// drops until it is taken; a new request is accepted in the same cycle the
// held response leaves.
// Reset empties the queue at once; no clearing pass is needed since slots
// at or beyond the count are never read.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top #(
    parameter int unsigned DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // [31:0] data_in, [47:32] prio_in
    input  logic        s_axis_tuser,   // [0] cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] data_out, [36:32] entry_count
    output logic [2:0]  m_axis_tuser    // [0] data_valid, [1] was_empty,
                                        // [2] rejected_full
);
    import spq_pkg::*;

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    dp_cmd_t            cmd;
    dp_status_t         status;
    logic [DATA_W-1:0]  head_data;
    logic [CNT_W-1:0]   cnt;
    logic [CNT_W-1:0]   cnt_next;
    logic [DATA_W-1:0]  data_out;
    logic               data_valid;
    logic               was_empty;
    logic               rejected_full;
    logic [COUNT_W-1:0] entry_count;

    spq_ctrl #(
        .CNT_W(CNT_W)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .cmd          (cmd),
        .status       (status),
        .head_data    (head_data),
        .cnt_next     (cnt_next),
        .data_out     (data_out),
        .data_valid   (data_valid),
        .was_empty    (was_empty),
        .rejected_full(rejected_full),
        .entry_count  (entry_count)
    );

    spq_datapath #(
        .DEPTH(DEPTH),
        .CNT_W(CNT_W)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .data_in  (s_axis_tdata[31:0]),
        .prio_in  (s_axis_tdata[47:32]),
        .status   (status),
        .head_data(head_data),
        .cnt      (cnt),
        .cnt_next (cnt_next)
    );

    assign m_axis_tdata = {3'b000, entry_count, data_out};
    assign m_axis_tuser = {rejected_full, was_empty, data_valid};

    // The count never passes the number of slots.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt <= CNT_W'(DEPTH))
        else $error("entry count exceeds queue depth");

    // A response carries at most one outcome flag.
    a_flags_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> $onehot0(m_axis_tuser))
        else $error("more than one outcome flag set");

    // An accepted enqueue into a non-full queue grows the count by one.
    a_enq_count: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_ENQ && !status.full)
        |=> (cnt == $past(cnt) + CNT_W'(1)))
        else $error("enqueue did not increment the count");

    // A dequeue from an empty queue leaves it empty and sets the was_empty flag.
    a_deq_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_DEQ && status.empty)
        |=> (status.empty && m_axis_tuser[1]))
        else $error("empty dequeue changed the queue or missed its flag");

endmodule
